/* rtl/tcw_pkg.sv */
// shared constants, payload types and codes of the text console writer
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int COL_W      = $clog2(COLUMNS + 1);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int IDX_W      = 11;
  localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;
  localparam logic [3:0] FG_RESET     = 4'hF;
  localparam logic [3:0] BG_RESET     = 4'h0;

  localparam logic [0:0] CFG_FG_COLOR = 1'b0;
  localparam logic [0:0] CFG_BG_COLOR = 1'b1;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] chr;
  } cell_t;

  typedef struct packed {
    op_e        opcode;
    logic [7:0] char_code;
    logic [10:0] cell_index;
  } in_word_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } out_word_t;

endpackage

/* rtl/tcw_cell_ram.sv */
// screen cell memory, one write port and one registered read port
module tcw_cell_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [tcw_pkg::ADDR_W-1:0] waddr_i,
  input  tcw_pkg::cell_t            wdata_i,
  input  logic                      re_i,
  input  logic [tcw_pkg::ADDR_W-1:0] raddr_i,
  output tcw_pkg::cell_t            rdata_o
);

  tcw_pkg::cell_t mem [tcw_pkg::CELL_COUNT];
  tcw_pkg::cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/text_console_writer_unit.sv */
// text console writer top level: cursor, command sequencer and screen memory
// A put, read, unused opcode or in-row newline is accepted in a cycle that, for a put or read,
// also does its one cell memory access; ST_RESP then loads its result into the output register.
// A newline on the bottom row, or a put there once the row is full, scrolls instead: ST_SCROLL
// copies the rows up, reading one cell while it writes the cell read before; ST_FILL blanks the
// bottom row; ST_WRITE writes the character (not for a newline); ST_RESP loads the result.
// Clear writes every cell in ST_FILL, then loads its result in ST_RESP. After reset the block
// runs a pass that fills the screen with spaces of attribute 0x0F and accepts no word until it
// ends; color writes are taken at any time. A new word is accepted while a result waits, but
// its own result stalls until the output register is free.
module text_console_writer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcw_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcw_pkg::out_word_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [3:0]         cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCROLL,
    ST_FILL,
    ST_WRITE,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    FM_INIT,
    FM_CLEAR,
    FM_SCROLL
  } fill_e;

  state_e state_q, state_d;
  fill_e  fill_q, fill_d;
  logic [tcw_pkg::CNT_W-1:0]  ptr_q, ptr_d;
  logic [tcw_pkg::ADDR_W-1:0] sa_q, sa_d;
  logic                       pend_q, pend_d;
  logic                       put_pend_q, put_pend_d;
  logic [7:0]                 chr_q, chr_d;
  logic                       rd_hit_q, rd_hit_d;
  logic [tcw_pkg::COL_W-1:0]  col_q, col_d;
  logic [tcw_pkg::ROW_W-1:0]  row_q, row_d;
  logic [3:0]                 fg_q, bg_q;
  logic                       out_valid_q, out_valid_d;
  tcw_pkg::out_word_t         out_q, out_d;

  logic                       mem_we, mem_re;
  logic [tcw_pkg::ADDR_W-1:0] mem_wa, mem_ra;
  tcw_pkg::cell_t             mem_wd, mem_rd;
  logic [7:0]                 attr;
  logic                       wrap, newline;
  logic [tcw_pkg::ROW_W-1:0]  eff_row;
  logic [tcw_pkg::COL_W-1:0]  eff_col;
  logic [tcw_pkg::CMP_W-1:0]  idx_ext;
  logic [tcw_pkg::CNT_W-1:0]  src_dst;

  function automatic logic [tcw_pkg::ADDR_W-1:0] cell_addr(
    input logic [tcw_pkg::ROW_W-1:0] row,
    input logic [tcw_pkg::COL_W-1:0] col
  );
    logic [tcw_pkg::CNT_W-1:0] s;
    s = tcw_pkg::CNT_W'(row) * tcw_pkg::CNT_W'(tcw_pkg::COLUMNS) + tcw_pkg::CNT_W'(col);
    return s[tcw_pkg::ADDR_W-1:0];
  endfunction

  tcw_cell_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .re_i    (mem_re),
    .raddr_i (mem_ra),
    .rdata_o (mem_rd)
  );

  assign attr       = {bg_q, fg_q};
  assign in_ready_o = (state_q == ST_IDLE);
  assign newline    = (in_data_i.char_code == tcw_pkg::NEWLINE_CODE);
  assign wrap       = newline || (col_q >= tcw_pkg::COL_W'(tcw_pkg::COLUMNS));
  assign eff_row    = wrap ? row_q + 1'b1 : row_q;
  assign eff_col    = wrap ? '0 : col_q;
  assign idx_ext    = tcw_pkg::CMP_W'(in_data_i.cell_index);
  assign src_dst    = ptr_q - tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    sa_d        = sa_q;
    pend_d      = pend_q;
    put_pend_d  = put_pend_q;
    chr_d       = chr_q;
    rd_hit_d    = rd_hit_q;
    col_d       = col_q;
    row_d       = row_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    mem_re      = 1'b0;
    mem_ra      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rd_hit_d = 1'b0;
          state_d  = ST_RESP;
          unique case (in_data_i.opcode)
            tcw_pkg::OP_PUT: begin
              if (wrap && (row_q >= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1))) begin
                // bottom row: scroll first, character goes in afterwards
                col_d      = '0;
                put_pend_d = !newline;
                chr_d      = in_data_i.char_code;
                ptr_d      = tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
                pend_d     = 1'b0;
                state_d    = ST_SCROLL;
              end else begin
                row_d = eff_row;
                col_d = eff_col;
                if (!newline) begin
                  mem_we = 1'b1;
                  mem_wa = cell_addr(eff_row, eff_col);
                  mem_wd = {attr, in_data_i.char_code};
                  col_d  = eff_col + 1'b1;
                end
              end
            end
            tcw_pkg::OP_CLEAR: begin
              ptr_d   = '0;
              fill_d  = FM_CLEAR;
              state_d = ST_FILL;
            end
            tcw_pkg::OP_READ: begin
              if (idx_ext < tcw_pkg::CMP_W'(tcw_pkg::CELL_COUNT)) begin
                mem_re   = 1'b1;
                mem_ra   = idx_ext[tcw_pkg::ADDR_W-1:0];
                rd_hit_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCROLL: begin
        // read one row down, write the cell read in the previous cycle
        if (pend_q) begin
          mem_we = 1'b1;
          mem_wa = sa_q;
          mem_wd = mem_rd;
        end
        if (ptr_q < tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT)) begin
          mem_re = 1'b1;
          mem_ra = ptr_q[tcw_pkg::ADDR_W-1:0];
          sa_d   = src_dst[tcw_pkg::ADDR_W-1:0];
          pend_d = 1'b1;
          ptr_d  = ptr_q + 1'b1;
        end else begin
          pend_d  = 1'b0;
          ptr_d   = tcw_pkg::CNT_W'(tcw_pkg::LAST_ROW_BASE);
          fill_d  = FM_SCROLL;
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        mem_wa = ptr_q[tcw_pkg::ADDR_W-1:0];
        mem_wd = (fill_q == FM_INIT) ? {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE}
                                     : {attr, tcw_pkg::SPACE_CODE};
        ptr_d  = ptr_q + 1'b1;
        if (ptr_q == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - 1)) begin
          unique case (fill_q)
            FM_INIT:   state_d = ST_IDLE;
            FM_CLEAR:  state_d = ST_RESP;
            FM_SCROLL: state_d = put_pend_q ? ST_WRITE : ST_RESP;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: begin
        mem_we     = 1'b1;
        mem_wa     = cell_addr(row_q, col_q);
        mem_wd     = {attr, chr_q};
        col_d      = col_q + 1'b1;
        put_pend_d = 1'b0;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.cursor_col   = 7'(col_q);
          out_d.cursor_row   = 5'(row_q);
          out_d.cell_char    = rd_hit_q ? mem_rd.chr : '0;
          out_d.cell_attr    = rd_hit_q ? mem_rd.attr : '0;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      fill_q      <= FM_INIT;
      ptr_q       <= '0;
      sa_q        <= '0;
      pend_q      <= 1'b0;
      put_pend_q  <= 1'b0;
      chr_q       <= '0;
      rd_hit_q    <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      sa_q        <= sa_d;
      pend_q      <= pend_d;
      put_pend_q  <= put_pend_d;
      chr_q       <= chr_d;
      rd_hit_q    <= rd_hit_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // color registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= tcw_pkg::FG_RESET;
      bg_q <= tcw_pkg::BG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcw_pkg::CFG_FG_COLOR: fg_q <= cfg_data_i;
        tcw_pkg::CFG_BG_COLOR: bg_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT))
    else $error("sweep pointer past end of screen");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q < tcw_pkg::ROW_W'(tcw_pkg::ROWS)) && (col_q <= tcw_pkg::COL_W'(tcw_pkg::COLUMNS)))
    else $error("cursor outside screen");

  a_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == ST_IDLE) |-> (in_valid_i && in_data_i.opcode == tcw_pkg::OP_PUT))
    else $error("cell write in idle without a put word");

  a_read_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_re && state_q == ST_IDLE) |=> (state_q == ST_RESP && rd_hit_q))
    else $error("cell read not followed by its result");
`endif

endmodule

/* tb/sv/text_console_writer_unit_tb.sv */
// testbench for the text console writer: scripted and random traffic checked against a predictor
`timescale 1ns / 100ps

module text_console_writer_unit_tb;

  localparam tcw_pkg::op_e OP_UNUSED  = tcw_pkg::op_e'(2'd3);
  localparam int unsigned  HOLD_CYCLES = 600;
  localparam int unsigned  TAIL_CYCLES = 20;
  localparam int unsigned  DRAIN_LIMIT = 20000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  tcw_pkg::in_word_t  in_data   = '0;
  logic               in_ready;
  logic               out_valid;
  logic               out_ready = 1'b0;
  tcw_pkg::out_word_t out_data;
  logic       cfg_we   = 1'b0;
  logic [0:0] cfg_idx  = tcw_pkg::CFG_FG_COLOR;
  logic [3:0] cfg_data = '0;

  // console predictor state
  logic [15:0] screen_mem [tcw_pkg::CELL_COUNT];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [3:0]  console_fg;
  logic [3:0]  console_bg;

  tcw_pkg::out_word_t expected_words [$];
  int unsigned words_sent;
  int unsigned mismatch_count;
  int unsigned idle_pct = 19;
  int unsigned hold_count;
  int unsigned hold_taken;
  int unsigned hold_left;

  text_console_writer_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [15:0] blank_cell();
    return {console_bg, console_fg, tcw_pkg::SPACE_CODE};
  endfunction

  function automatic void advance_row();
    int unsigned i;
    cur_col = 0;
    if (cur_row < tcw_pkg::ROWS - 1) begin
      cur_row++;
    end else begin
      for (i = tcw_pkg::COLUMNS; i < tcw_pkg::CELL_COUNT; i++)
        screen_mem[i - tcw_pkg::COLUMNS] = screen_mem[i];
      for (i = tcw_pkg::LAST_ROW_BASE; i < tcw_pkg::CELL_COUNT; i++)
        screen_mem[i] = blank_cell();
    end
  endfunction

  function automatic void put_char(input logic [7:0] ch);
    if (ch == tcw_pkg::NEWLINE_CODE) begin
      advance_row();
    end else begin
      if (cur_col >= tcw_pkg::COLUMNS) advance_row();
      screen_mem[cur_row * tcw_pkg::COLUMNS + cur_col] = {console_bg, console_fg, ch};
      cur_col++;
    end
  endfunction

  function automatic tcw_pkg::out_word_t console_step(input tcw_pkg::in_word_t w);
    tcw_pkg::out_word_t res;
    int unsigned i;
    res = '0;
    case (w.opcode)
      tcw_pkg::OP_PUT: begin
        put_char(w.char_code);
      end
      tcw_pkg::OP_CLEAR: begin
        for (i = 0; i < tcw_pkg::CELL_COUNT; i++) screen_mem[i] = blank_cell();
      end
      tcw_pkg::OP_READ: begin
        if (w.cell_index < tcw_pkg::CELL_COUNT) begin
          res.cell_char = screen_mem[w.cell_index][7:0];
          res.cell_attr = screen_mem[w.cell_index][15:8];
        end
      end
      default: begin
      end
    endcase
    res.cursor_col = 7'(cur_col);
    res.cursor_row = 5'(cur_row);
    return res;
  endfunction

  function automatic tcw_pkg::in_word_t mk_word(input tcw_pkg::op_e op, input logic [7:0] ch,
                                                input logic [10:0] idx);
    tcw_pkg::in_word_t w;
    w.opcode     = op;
    w.char_code  = ch;
    w.cell_index = idx;
    return w;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(255)); while (ch == tcw_pkg::NEWLINE_CODE);
    return ch;
  endfunction

  function automatic logic [10:0] read_addr();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55)
      return 11'(cur_row * tcw_pkg::COLUMNS + $urandom_range(tcw_pkg::COLUMNS - 1));
    if (pick < 80) return 11'($urandom_range(tcw_pkg::CELL_COUNT - 1));
    if (pick < 90) return 11'($urandom_range(2047, tcw_pkg::CELL_COUNT));
    return 11'($urandom_range(2047));
  endfunction

  function automatic tcw_pkg::in_word_t noise_word();
    int unsigned pick;
    logic [7:0]  ch;
    logic [10:0] idx;
    pick = $urandom_range(99);
    ch   = 8'($urandom_range(255));
    idx  = 11'($urandom_range(2047));
    if (pick < 45) return mk_word(tcw_pkg::OP_READ, ch, read_addr());
    if (pick < 65) return mk_word(OP_UNUSED, ch, idx);
    if (pick < 75) return mk_word(tcw_pkg::OP_CLEAR, ch, idx);
    return mk_word(tcw_pkg::OP_PUT, ch, idx);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic send_word(input tcw_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_words.push_back(console_step(w));
    words_sent++;
  endtask

  task automatic send_put(input logic [7:0] ch);
    send_word(mk_word(tcw_pkg::OP_PUT, ch, 11'($urandom_range(2047))));
  endtask

  task automatic send_read(input logic [10:0] idx);
    send_word(mk_word(tcw_pkg::OP_READ, 8'($urandom_range(255)), idx));
  endtask

  task automatic wait_idle();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_colors(input logic [3:0] fg, input logic [3:0] bg);
    cfg_we   <= 1'b1;
    cfg_idx  <= tcw_pkg::CFG_FG_COLOR;
    cfg_data <= fg;
    @(posedge clk);
    console_fg = fg;
    cfg_idx  <= tcw_pkg::CFG_BG_COLOR;
    cfg_data <= bg;
    @(posedge clk);
    console_bg = bg;
    cfg_we <= 1'b0;
  endtask

  // lines of text with reads mixed in, plus some stray commands
  task automatic run_text(input int unsigned n);
    int unsigned stop_at;
    int unsigned len;
    int unsigned pick;
    int unsigned k;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 75) begin
        pick = $urandom_range(99);
        if (pick < 50) len = $urandom_range(4);
        else if (pick < 85) len = $urandom_range(30, 5);
        else len = $urandom_range(85, 75);
        for (k = 0; k < len && words_sent < stop_at; k++) begin
          send_put(text_char());
          if (words_sent < stop_at && $urandom_range(99) < 15) send_read(read_addr());
        end
        if (words_sent < stop_at && $urandom_range(99) < 80)
          send_put(tcw_pkg::NEWLINE_CODE);
      end else begin
        send_word(noise_word());
      end
    end
  endtask

  task automatic test_reads_after_reset();
    send_read(11'd0);
    send_read(11'(tcw_pkg::CELL_COUNT - 1));
    send_read(11'(tcw_pkg::CELL_COUNT));
    send_read(11'd2047);
    send_read(11'd1024);
    send_read(11'd1023);
    send_word(mk_word(OP_UNUSED, 8'hFF, 11'd2047));
  endtask

  task automatic test_put_extremes();
    send_put(8'h00);
    send_put(8'hFF);
    send_put(8'h41);
    send_put(tcw_pkg::NEWLINE_CODE);
    send_read(11'd0);
    send_read(11'd1);
    send_read(11'd2);
    send_word(mk_word(tcw_pkg::OP_CLEAR, 8'hFF, 11'd2047));
    send_read(11'd1);
    send_word(mk_word(OP_UNUSED, 8'h00, 11'd0));
  endtask

  task automatic test_full_row_newline();
    int unsigned k;
    send_put(tcw_pkg::NEWLINE_CODE);
    for (k = 0; k < tcw_pkg::COLUMNS; k++) send_put(text_char());
    send_read(11'(cur_row * tcw_pkg::COLUMNS + tcw_pkg::COLUMNS - 1));
    send_put(tcw_pkg::NEWLINE_CODE);
    send_read(11'((cur_row - 1) * tcw_pkg::COLUMNS));
  endtask

  task automatic test_scroll();
    int unsigned k;
    while (cur_row < tcw_pkg::ROWS - 1) send_put(tcw_pkg::NEWLINE_CODE);
    send_put(text_char());
    send_put(tcw_pkg::NEWLINE_CODE);
    send_read(11'(tcw_pkg::LAST_ROW_BASE - tcw_pkg::COLUMNS));
    send_read(11'(tcw_pkg::LAST_ROW_BASE));
    for (k = 0; k < tcw_pkg::COLUMNS; k++) send_put(text_char());
    send_put(text_char());
    send_read(11'(tcw_pkg::LAST_ROW_BASE));
    send_read(11'(tcw_pkg::LAST_ROW_BASE - 1));
    send_read(11'(tcw_pkg::CELL_COUNT - 1));
  endtask

  task automatic test_colors();
    logic [3:0] fg_list [5];
    logic [3:0] bg_list [5];
    int unsigned s;
    fg_list = '{4'h0, 4'hF, 4'h0, 4'($urandom_range(15)), tcw_pkg::FG_RESET};
    bg_list = '{4'hF, 4'hF, 4'h0, 4'($urandom_range(15)), tcw_pkg::BG_RESET};
    for (s = 0; s < 5; s++) begin
      wait_idle();
      write_colors(fg_list[s], bg_list[s]);
      send_word(mk_word(tcw_pkg::OP_CLEAR, 8'($urandom_range(255)),
                        11'($urandom_range(2047))));
      run_text(40);
    end
  endtask

  task automatic test_backpressure();
    hold_count++;
    run_text(40);
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    run_text(60);
    idle_pct = 19;
  endtask

  // receiver side: random stalls, and a long hold when one is requested
  always @(posedge clk) begin
    if (hold_taken != hold_count) begin
      hold_taken = hold_count;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    tcw_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing pending, cursor_col", out_data.cursor_col, 0);
      end else begin
        want = expected_words.pop_front();
        if (out_data.cursor_col != want.cursor_col)
          report_mismatch("cursor_col", out_data.cursor_col, want.cursor_col);
        if (out_data.cursor_row != want.cursor_row)
          report_mismatch("cursor_row", out_data.cursor_row, want.cursor_row);
        if (out_data.cell_char != want.cell_char)
          report_mismatch("cell_char", out_data.cell_char, want.cell_char);
        if (out_data.cell_attr != want.cell_attr)
          report_mismatch("cell_attr", out_data.cell_attr, want.cell_attr);
      end
    end
  end

  initial begin
    for (int i = 0; i < tcw_pkg::CELL_COUNT; i++)
      screen_mem[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE};
    cur_col    = 0;
    cur_row    = 0;
    console_fg = tcw_pkg::FG_RESET;
    console_bg = tcw_pkg::BG_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reads_after_reset();
    test_put_extremes();
    test_full_row_newline();
    test_scroll();
    test_colors();
    test_backpressure();
    test_no_idle();
    run_text(40);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch("words never delivered", 0, expected_words.size());
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* text_console_writer_unit.f */
rtl/tcw_pkg.sv
rtl/tcw_cell_ram.sv
rtl/text_console_writer_unit.sv
tb/sv/text_console_writer_unit_tb.sv
